>>> hw/rtl/wfcvf_pkg.sv
// ----------------------------------------------------------------------------
// wfcvf_pkg: shared definitions for the wait-for cycle victim finder
// Sizes, field widths, command codes, sequencer states and edge record.
// ----------------------------------------------------------------------------
`default_nettype none

package wfcvf_pkg;

    localparam int MAX_ENTITIES  = 64;
    localparam int NUM_RESOURCES = 3;

    localparam int ENT_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam int RES_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int WR_W    = 3;
    localparam int HOLD_W  = 7;
    localparam int ECNT_W  = 7;
    localparam int VICT_W  = 6;
    localparam int IDATA_W = 24;
    localparam int ODATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_WAIT   = 2'd0,
        CMD_SET_HOLDER = 2'd1,
        CMD_DETECT     = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_STEP,
        ST_WALK_FETCH,
        ST_WALK_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ENT_W-1:0] ent;
    } t_edge;

endpackage

`default_nettype wire

>>> hw/rtl/wait_for_cycle_victim_finder_top.sv
// ----------------------------------------------------------------------------
// wait_for_cycle_victim_finder_top: wait-for graph deadlock victim finder
// Keeps who-waits-on-what tables and searches the wait-for graph for a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser carries the command; tdata carries slot,
//   wait resource, holder and entity count. Set commands update the wait
//   table or the holder table and produce no output. A detect command walks
//   the graph over the first entity_count entities and produces one output
//   transfer: tuser = found, tdata = victim (largest entity in the first
//   cycle reached, zero when none).
//   Timing: set commands are accepted every cycle while idle. A detect tries
//   each root in turn, and for each entity followed along a chain or along
//   the cycle walk it does a wait table RAM read, then an edge resolve. The
//   single wait table read port and the shared edge resolver serialise these
//   steps. s_axis_tready is low during a detect.
//   Reset: both tables read back as not waiting / unheld, no output pending.
//   Stall: the result sits in an output register; set commands are still
//   accepted while it waits, a following detect is searched and then holds,
//   with s_axis_tready low, until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wait_for_cycle_victim_finder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] slot, [8:6] wait_resource, [15:9] holder, [22:16] entity_count
    input  wire logic [wfcvf_pkg::IDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [wfcvf_pkg::CMD_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] victim
    output logic      [wfcvf_pkg::ODATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                               m_axis_tuser
);

    wfcvf_pkg::t_state r_state, n_state;
    wfcvf_pkg::t_cmd   cmd;
    wfcvf_pkg::t_edge  edge_q;

    logic [wfcvf_pkg::SLOT_W-1:0] in_slot;
    logic [wfcvf_pkg::WR_W-1:0]   in_wait;
    logic [wfcvf_pkg::HOLD_W-1:0] in_holder;
    logic [wfcvf_pkg::ECNT_W-1:0] in_count;
    logic [wfcvf_pkg::CNT_W-1:0]  sat_count;

    logic [wfcvf_pkg::MAX_ENTITIES-1:0] r_visited;
    logic [wfcvf_pkg::MAX_ENTITIES-1:0] r_onchain;
    logic [wfcvf_pkg::CNT_W-1:0]        r_cnt;
    logic [wfcvf_pkg::CNT_W-1:0]        r_root;
    logic [wfcvf_pkg::ENT_W-1:0]        r_cur;
    logic [wfcvf_pkg::ENT_W-1:0]        r_cyc;
    logic [wfcvf_pkg::ENT_W-1:0]        r_best;
    logic                               r_found;
    logic                               r_out_valid;
    logic                               r_out_found;
    logic [wfcvf_pkg::VICT_W-1:0]       r_out_victim;

    logic [wfcvf_pkg::WR_W-1:0]  wait_q;
    logic [wfcvf_pkg::ENT_W-1:0] root_idx;
    logic in_xfer, wait_wr, hold_wr;
    logic scan_end, root_seen, step_end, step_loop, walk_close;
    logic start, root_inc, enter, chain_end, walk_start, walk_adv, close_found, out_load;
    logic [wfcvf_pkg::ENT_W-1:0] enter_idx;

    assign in_slot   = s_axis_tdata[5:0];
    assign in_wait   = s_axis_tdata[8:6];
    assign in_holder = s_axis_tdata[15:9];
    assign in_count  = s_axis_tdata[22:16];
    assign cmd       = wfcvf_pkg::t_cmd'(s_axis_tuser);
    assign sat_count = (32'(in_count) > 32'(wfcvf_pkg::MAX_ENTITIES))
                     ? wfcvf_pkg::CNT_W'(wfcvf_pkg::MAX_ENTITIES)
                     : wfcvf_pkg::CNT_W'(in_count);

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign wait_wr = in_xfer && (cmd == wfcvf_pkg::CMD_SET_WAIT) &&
                     (32'(in_slot) < 32'(wfcvf_pkg::MAX_ENTITIES));
    assign hold_wr = in_xfer && (cmd == wfcvf_pkg::CMD_SET_HOLDER) &&
                     (32'(in_slot) < 32'(wfcvf_pkg::NUM_RESOURCES));

    wfcvf_wait_tbl u_wait_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wait_wr),
        .i_wr_addr (wfcvf_pkg::ENT_W'(in_slot)),
        .i_wr_data (in_wait),
        .i_rd_addr (r_cur),
        .o_rd_data (wait_q)
    );

    wfcvf_edge u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (hold_wr),
        .i_wr_idx  (wfcvf_pkg::RES_W'(in_slot)),
        .i_wr_data (in_holder),
        .i_res     (wait_q),
        .i_ent     (r_cur),
        .i_cnt     (r_cnt),
        .o_edge    (edge_q)
    );

    assign root_idx   = r_root[wfcvf_pkg::ENT_W-1:0];
    assign scan_end   = (r_root == r_cnt);
    assign root_seen  = r_visited[root_idx];
    assign step_end   = !edge_q.valid || (r_visited[edge_q.ent] && !r_onchain[edge_q.ent]);
    assign step_loop  = r_onchain[edge_q.ent];
    assign walk_close = !edge_q.valid || (edge_q.ent == r_cyc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wfcvf_pkg::ST_IDLE: begin
                if (in_xfer && (cmd == wfcvf_pkg::CMD_DETECT)) begin
                    n_state = wfcvf_pkg::ST_SCAN;
                end
            end
            wfcvf_pkg::ST_SCAN: begin
                priority if (scan_end) begin
                    n_state = wfcvf_pkg::ST_DONE;
                end else if (!root_seen) begin
                    n_state = wfcvf_pkg::ST_FETCH;
                end
            end
            wfcvf_pkg::ST_FETCH:      n_state = wfcvf_pkg::ST_STEP;
            wfcvf_pkg::ST_STEP: begin
                priority if (step_end) begin
                    n_state = wfcvf_pkg::ST_SCAN;
                end else if (step_loop) begin
                    n_state = wfcvf_pkg::ST_WALK_FETCH;
                end else begin
                    n_state = wfcvf_pkg::ST_FETCH;
                end
            end
            wfcvf_pkg::ST_WALK_FETCH: n_state = wfcvf_pkg::ST_WALK_STEP;
            wfcvf_pkg::ST_WALK_STEP: begin
                n_state = walk_close ? wfcvf_pkg::ST_DONE : wfcvf_pkg::ST_WALK_FETCH;
            end
            wfcvf_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = wfcvf_pkg::ST_IDLE;
                end
            end
            default:                  n_state = wfcvf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        start         = 1'b0;
        root_inc      = 1'b0;
        enter         = 1'b0;
        enter_idx     = root_idx;
        chain_end     = 1'b0;
        walk_start    = 1'b0;
        walk_adv      = 1'b0;
        close_found   = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            wfcvf_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                start         = s_axis_tvalid && (cmd == wfcvf_pkg::CMD_DETECT);
            end
            wfcvf_pkg::ST_SCAN: begin
                priority if (scan_end) begin
                    root_inc = 1'b0;
                end else if (root_seen) begin
                    root_inc = 1'b1;
                end else begin
                    enter = 1'b1;
                end
            end
            wfcvf_pkg::ST_STEP: begin
                priority if (step_end) begin
                    chain_end = 1'b1;
                    root_inc  = 1'b1;
                end else if (step_loop) begin
                    walk_start = 1'b1;
                end else begin
                    enter     = 1'b1;
                    enter_idx = edge_q.ent;
                end
            end
            wfcvf_pkg::ST_WALK_STEP: begin
                if (walk_close) begin
                    close_found = 1'b1;
                end else begin
                    walk_adv = 1'b1;
                end
            end
            wfcvf_pkg::ST_DONE: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                start = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfcvf_pkg::ST_IDLE;
            r_visited   <= '0;
            r_onchain   <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_visited <= '0;
                r_onchain <= '0;
                r_root    <= '0;
            end
            if (chain_end) begin
                r_onchain <= '0;
            end
            if (enter) begin
                r_visited[enter_idx] <= 1'b1;
                r_onchain[enter_idx] <= 1'b1;
            end
            if (root_inc) begin
                r_root <= r_root + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cnt   <= sat_count;
            r_found <= 1'b0;
        end
        if (enter) begin
            r_cur <= enter_idx;
        end
        if (walk_start) begin
            r_cyc  <= edge_q.ent;
            r_best <= edge_q.ent;
            r_cur  <= edge_q.ent;
        end
        if (walk_adv) begin
            r_cur <= edge_q.ent;
            if (edge_q.ent > r_best) begin
                r_best <= edge_q.ent;
            end
        end
        if (close_found) begin
            r_found <= 1'b1;
        end
        if (out_load) begin
            r_out_found  <= r_found;
            r_out_victim <= r_found ? wfcvf_pkg::VICT_W'(r_best) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = wfcvf_pkg::ODATA_W'(r_out_victim);

    a_chain_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_onchain & ~r_visited) == '0)
        else $error("on-chain entity not marked visited");

    a_walk_on_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfcvf_pkg::ST_WALK_FETCH || r_state == wfcvf_pkg::ST_WALK_STEP)
        |-> r_onchain[r_cur])
        else $error("cycle walk left the current chain");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfcvf_pkg::ST_SCAN) |-> (r_root <= r_cnt))
        else $error("root index passed entity count");

    a_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_victim == '0))
        else $error("victim set without a cycle");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfcvf_pkg::ST_STEP) |=> !start)
        else $error("detect started during a search");

endmodule

`default_nettype wire

>>> hw/rtl/wfcvf_ram.sv
// ----------------------------------------------------------------------------
// wfcvf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfcvf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/wfcvf_wait_tbl.sv
// ----------------------------------------------------------------------------
// wfcvf_wait_tbl: per-entity awaited resource table
// RAM plus one valid bit per entry; an unwritten entry reads as not waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module wfcvf_wait_tbl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [wfcvf_pkg::ENT_W-1:0] i_wr_addr,
    input  wire logic [wfcvf_pkg::WR_W-1:0]  i_wr_data,
    input  wire logic [wfcvf_pkg::ENT_W-1:0] i_rd_addr,
    output logic      [wfcvf_pkg::WR_W-1:0]  o_rd_data
);

    logic [wfcvf_pkg::MAX_ENTITIES-1:0] r_valid;
    logic                               r_rd_valid;
    logic [wfcvf_pkg::WR_W-1:0]         ram_q;

    wfcvf_ram #(
        .DEPTH (wfcvf_pkg::MAX_ENTITIES),
        .WIDTH (wfcvf_pkg::WR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? ram_q : '1;

endmodule

`default_nettype wire

>>> hw/rtl/wfcvf_edge.sv
// ----------------------------------------------------------------------------
// wfcvf_edge: holder table and wait-for edge resolver
// Maps an entity and its awaited resource to the holding entity, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module wfcvf_edge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [wfcvf_pkg::RES_W-1:0]  i_wr_idx,
    input  wire logic [wfcvf_pkg::HOLD_W-1:0] i_wr_data,
    input  wire logic [wfcvf_pkg::WR_W-1:0]   i_res,
    input  wire logic [wfcvf_pkg::ENT_W-1:0]  i_ent,
    input  wire logic [wfcvf_pkg::CNT_W-1:0]  i_cnt,
    output wfcvf_pkg::t_edge                  o_edge
);

    logic [wfcvf_pkg::HOLD_W-1:0] r_holder [wfcvf_pkg::NUM_RESOURCES];
    logic                         res_ok;
    logic [wfcvf_pkg::RES_W-1:0]  res_idx;
    logic [wfcvf_pkg::HOLD_W-1:0] hold;
    logic [31:0]                  hold_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wfcvf_pkg::NUM_RESOURCES; i++) begin
                r_holder[i] <= '1;
            end
        end else if (i_wr_en) begin
            r_holder[i_wr_idx] <= i_wr_data;
        end
    end

    always_comb begin
        res_ok  = !i_res[wfcvf_pkg::WR_W-1] &&
                  (32'(i_res[wfcvf_pkg::WR_W-2:0]) < 32'(wfcvf_pkg::NUM_RESOURCES));
        res_idx = wfcvf_pkg::RES_W'(i_res[wfcvf_pkg::WR_W-2:0]);
        hold    = '1;
        for (int i = 0; i < wfcvf_pkg::NUM_RESOURCES; i++) begin
            if (res_ok && (res_idx == wfcvf_pkg::RES_W'(i))) begin
                hold = r_holder[i];
            end
        end
        hold_ext     = 32'(hold[wfcvf_pkg::HOLD_W-2:0]);
        o_edge.valid = !hold[wfcvf_pkg::HOLD_W-1] &&
                       (hold_ext < 32'(i_cnt)) &&
                       (hold_ext != 32'(i_ent));
        o_edge.ent   = wfcvf_pkg::ENT_W'(hold[wfcvf_pkg::HOLD_W-2:0]);
    end

endmodule

`default_nettype wire

>>> verif/tb_wait_for_cycle_victim_finder_top.sv
// ----------------------------------------------------------------------------
// tb_wait_for_cycle_victim_finder_top: self-checking bench for the victim finder
// Drives set-wait, set-holder, detect and unused commands. A directed table
// comes first, then random traffic built around small wait-for graphs. A local
// copy of both tables predicts every detect result no directed row fixes. Both
// stream sides idle in random bursts, and the final stretch runs without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wait_for_cycle_victim_finder_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 500;
    localparam int QUIET_ITEMS    = 60;

    typedef struct packed {
        logic                         found;
        logic [wfcvf_pkg::VICT_W-1:0] victim;
    } t_verdict;

    typedef struct packed {
        wfcvf_pkg::t_cmd                     op;
        logic [wfcvf_pkg::SLOT_W-1:0]        slot;
        logic signed [wfcvf_pkg::WR_W-1:0]   wres;
        logic signed [wfcvf_pkg::HOLD_W-1:0] hold;
        logic [wfcvf_pkg::ECNT_W-1:0]        cnt;
        logic                                typed;
        t_verdict                            known;
    } t_step;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [wfcvf_pkg::IDATA_W-1:0]   s_axis_tdata;   // [5:0] slot, [8:6] wait_resource,
                                                     // [15:9] holder, [22:16] entity_count
    logic [wfcvf_pkg::CMD_W-1:0]     s_axis_tuser;   // [1:0] cmd
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [wfcvf_pkg::ODATA_W-1:0]   m_axis_tdata;   // [5:0] victim
    logic                            m_axis_tuser;   // [0] found

    logic signed [wfcvf_pkg::WR_W-1:0]   wait_on [wfcvf_pkg::MAX_ENTITIES];
    logic signed [wfcvf_pkg::HOLD_W-1:0] held_by [wfcvf_pkg::NUM_RESOURCES];
    t_verdict                            verdict_q [$];
    t_step                               script [$];
    int                                  mismatches = 0;
    int                                  quiet_cycles = 0;
    int                                  tx_idle_pct;
    int                                  rx_idle_pct;
    int                                  rx_hold = 0;

    wait_for_cycle_victim_finder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // entity the given entity waits for, -1 when it has no edge
    function automatic int blocker_of(int ent, int n);
        int r;
        int h;
        r = wait_on[ent];
        if (r < 0 || r >= wfcvf_pkg::NUM_RESOURCES) return -1;
        h = held_by[r];
        if (h >= 0 && h < n && h != ent) return h;
        return -1;
    endfunction

    function automatic t_verdict find_victim(int n);
        int       marks [wfcvf_pkg::MAX_ENTITIES];
        int       path [wfcvf_pkg::MAX_ENTITIES];
        int       depth;
        int       u;
        int       v;
        int       best;
        bit       done;
        t_verdict res;
        res = '0;
        for (int i = 0; i < wfcvf_pkg::MAX_ENTITIES; i++) marks[i] = 0;
        for (int i = 0; i < n; i++) begin
            if (marks[i] != 0) continue;
            depth = 0;
            u = i;
            done = 1'b0;
            while (!done) begin
                marks[u] = 1;
                path[depth] = u;
                depth++;
                v = blocker_of(u, n);
                if (v < 0 || marks[v] == 2) begin
                    done = 1'b1;
                end else if (marks[v] == 1) begin
                    best = v;
                    for (int k = depth - 1; k >= 0; k--) begin
                        if (path[k] > best) best = path[k];
                        if (path[k] == v) break;
                    end
                    res.found = 1'b1;
                    res.victim = best[wfcvf_pkg::VICT_W-1:0];
                    return res;
                end else if (depth >= wfcvf_pkg::MAX_ENTITIES) begin
                    done = 1'b1;
                end else begin
                    u = v;
                end
            end
            for (int k = 0; k < depth; k++) marks[path[k]] = 2;
        end
        return res;
    endfunction

    task automatic add_row(input t_step row);
        script = {script, row};
    endtask

    // drive one command, wait for its transfer, then update the local tables
    task automatic send_step(t_step st);
        int       gap;
        int       n;
        t_verdict v;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= st.op;
        s_axis_tdata  <= {1'b0, st.cnt, st.hold, st.wres, st.slot};
        do @(posedge i_clk); while (!s_axis_tready);
        case (st.op)
            wfcvf_pkg::CMD_SET_WAIT: begin
                if (st.slot < wfcvf_pkg::MAX_ENTITIES) wait_on[st.slot] = st.wres;
            end
            wfcvf_pkg::CMD_SET_HOLDER: begin
                if (st.slot < wfcvf_pkg::NUM_RESOURCES) held_by[st.slot] = st.hold;
            end
            wfcvf_pkg::CMD_DETECT: begin
                n = (st.cnt > wfcvf_pkg::MAX_ENTITIES) ? wfcvf_pkg::MAX_ENTITIES
                                                       : int'(st.cnt);
                v = find_victim(n);
                verdict_q = {verdict_q, (st.typed ? st.known : v)};
            end
            default: ;
        endcase
    endtask

    // result side: m_axis_tready drops in random stall bursts
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual found=%0d victim=%0d",
                         $time, m_axis_tuser, m_axis_tdata[wfcvf_pkg::VICT_W-1:0]);
                mismatches++;
            end else begin
                if (m_axis_tuser !== verdict_q[0].found) begin
                    $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                             verdict_q[0].found, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[wfcvf_pkg::VICT_W-1:0] !== verdict_q[0].victim) begin
                    $display("%0t: victim mismatch: expected %0d, actual %0d", $time,
                             verdict_q[0].victim, m_axis_tdata[wfcvf_pkg::VICT_W-1:0]);
                    mismatches++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_step st;
        int    span;
        int    sel;
        int    applied;
        int    spans [4];
        int    idles [4];

        spans = '{4, 8, 16, 64};
        idles = '{0, 10, 30, 60};
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = wfcvf_pkg::CMD_NOP;
        for (int i = 0; i < wfcvf_pkg::MAX_ENTITIES; i++) wait_on[i] = '1;
        for (int i = 0; i < wfcvf_pkg::NUM_RESOURCES; i++) held_by[i] = '1;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // op, slot, wait_resource, holder, count, typed, {found, victim}
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd0,   1'b1, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b1, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd63, -3'sd1, -7'sd1,  7'd127, 1'b1, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd0,  3'sd0,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd0,  3'sd0,  7'sd1,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd1,  3'sd1,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd1,  3'sd0,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd2,   1'b1,
                  {1'b1, 6'd1}});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd1,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_NOP,        6'd63, -3'sd1, -7'sd1,  7'd127, 1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd3,  3'sd0,  7'sd63,  7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd63, 3'sd0,  -7'sd64, 7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd1,  3'sd3,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd1,  -3'sd4, 7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd63, 3'sd2,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd2,  3'sd0,  7'sd63,  7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd2,  3'sd0,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_WAIT,   6'd1,  3'sd2,  7'sd0,   7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd0,  3'sd0,  -7'sd64, 7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_SET_HOLDER, 6'd1,  3'sd0,  7'sd63,  7'd0,   1'b0, 7'd0});
        add_row('{wfcvf_pkg::CMD_DETECT,     6'd0,  3'sd0,  7'sd0,   7'd64,  1'b0, 7'd0});

        foreach (script[i]) send_step(script[i]);

        // random traffic, reshaped every 50 items: graph span and idle rates
        applied = 0;
        span = 8;
        while (applied < RANDOM_ITEMS) begin
            if (applied % 50 == 0) begin
                span = spans[$urandom_range(0, 3)];
                tx_idle_pct = idles[$urandom_range(0, 3)];
                rx_idle_pct = idles[$urandom_range(0, 3)];
            end
            if (applied >= RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            st = '0;
            st.slot = wfcvf_pkg::SLOT_W'($urandom());
            st.wres = wfcvf_pkg::WR_W'($urandom());
            st.hold = wfcvf_pkg::HOLD_W'($urandom());
            st.cnt = wfcvf_pkg::ECNT_W'($urandom());
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                st.op = wfcvf_pkg::CMD_NOP;
            end else if (sel < 45) begin
                st.op = wfcvf_pkg::CMD_SET_WAIT;
                if ($urandom_range(0, 9) != 0)
                    st.slot = wfcvf_pkg::SLOT_W'($urandom_range(0, span - 1));
                if ($urandom_range(0, 4) != 0)
                    st.wres = wfcvf_pkg::WR_W'($urandom_range(0,
                                                   wfcvf_pkg::NUM_RESOURCES - 1));
            end else if (sel < 72) begin
                st.op = wfcvf_pkg::CMD_SET_HOLDER;
                if ($urandom_range(0, 6) != 0)
                    st.slot = wfcvf_pkg::SLOT_W'($urandom_range(0,
                                                     wfcvf_pkg::NUM_RESOURCES - 1));
                if ($urandom_range(0, 3) != 0)
                    st.hold = wfcvf_pkg::HOLD_W'($urandom_range(0, span - 1));
            end else begin
                st.op = wfcvf_pkg::CMD_DETECT;
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    st.cnt = wfcvf_pkg::ECNT_W'($urandom_range(0, span));
                else if (sel < 85)
                    st.cnt = wfcvf_pkg::ECNT_W'(wfcvf_pkg::MAX_ENTITIES);
            end
            send_step(st);
            applied++;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/wfcvf_pkg.sv
hw/rtl/wfcvf_ram.sv
hw/rtl/wfcvf_wait_tbl.sv
hw/rtl/wfcvf_edge.sv
hw/rtl/wait_for_cycle_victim_finder_top.sv
verif/tb_wait_for_cycle_victim_finder_top.sv
